FILE: hdl/mtsl_pkg.sv
package mtsl_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = 11;
  localparam int DATA_W  = 32;

  // Register index of list_length on the configuration port.
  localparam logic REG_LIST_LENGTH = 1'b0;

  // Handshake between the loader and the search unit.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] last;
    logic              out_free;
  } srch_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
  } srch_stat_t;

endpackage

FILE: hdl/mtsl_ram.sv
module mtsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mtsl_search.sv
module mtsl_search
  import mtsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  srch_cmd_t         cmd,
  output srch_stat_t        stat,
  output logic [ADDR_W-1:0] raddr_a,
  output logic [ADDR_W-1:0] raddr_b,
  input  logic [DATA_W-1:0] rdata_a,
  input  logic [DATA_W-1:0] rdata_b
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_LO    = 3'd3;
  localparam logic [2:0] S_HI    = 3'd4;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] la, ra, lb, rb;
  logic [ADDR_W-1:0] la_next, ra_next, lb_next, rb_next;
  logic [DATA_W-1:0] lo_a, lo_b;
  logic [ADDR_W:0]   sum_a, sum_b;
  logic [ADDR_W-1:0] ma, mb, span;
  logic              even, a_less, lo_less;
  logic [DATA_W-1:0] pick_x, pick_y;
  logic              done;

  assign sum_a  = {1'b0, la} + {1'b0, ra};
  assign sum_b  = {1'b0, lb} + {1'b0, rb};
  assign ma     = sum_a[ADDR_W:1];
  assign mb     = sum_b[ADDR_W:1];
  assign span   = ra - la;
  // An even number of remaining elements means the index span is odd.
  assign even   = span[0];
  assign a_less = $signed(rdata_a) < $signed(rdata_b);

  // Final step: with A[la] below B[lb] the answer is min(A[ra], B[lb]),
  // otherwise min(A[la], B[rb]).
  assign lo_less = $signed(lo_a) < $signed(lo_b);
  assign pick_x  = lo_less ? rdata_a : lo_a;
  assign pick_y  = lo_less ? lo_b : rdata_b;

  always_comb begin
    state_next = state;
    la_next    = la;
    ra_next    = ra;
    lb_next    = lb;
    rb_next    = rb;
    raddr_a    = la;
    raddr_b    = lb;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          la_next    = '0;
          ra_next    = cmd.last;
          lb_next    = '0;
          rb_next    = cmd.last;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (span >= ADDR_W'(2)) begin
          raddr_a    = ma;
          raddr_b    = mb;
          state_next = S_CMP;
        end else begin
          state_next = S_LO;
        end
      end
      S_CMP: begin
        if (a_less) begin
          la_next = even ? ma + 1'b1 : ma;
          rb_next = mb;
        end else begin
          ra_next = ma;
          lb_next = even ? mb + 1'b1 : mb;
        end
        state_next = S_CHECK;
      end
      S_LO: begin
        raddr_a    = ra;
        raddr_b    = rb;
        state_next = S_HI;
      end
      S_HI: begin
        // The read addresses stay put, so the read data holds while waiting.
        raddr_a = ra;
        raddr_b = rb;
        if (cmd.out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign stat.done   = done;
  assign stat.busy   = state != S_IDLE;
  assign stat.result = ($signed(pick_x) < $signed(pick_y)) ? pick_x : pick_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      la    <= '0;
      ra    <= '0;
      lb    <= '0;
      rb    <= '0;
    end else begin
      state <= state_next;
      la    <= la_next;
      ra    <= ra_next;
      lb    <= lb_next;
      rb    <= rb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LO) begin
      lo_a <= rdata_a;
      lo_b <= rdata_b;
    end
  end

endmodule

FILE: hdl/median_of_two_sorted_lists_core.sv
// Lower median of two sorted lists of n signed 32-bit values each. n is set through register
// list_length at address 0 (0 counts as 1, values above 1024 as 1024); writing it restarts
// loading with list A. Values arrive on the input stream one per cycle while no search runs,
// the first n forming list A and the next n list B, and are written into two 1024-entry
// memories. After the last value of B the input is held off while a halving search runs over
// the memories: each round reads both middle elements and then compares them, over
// ceil(log2(n))-1 rounds (none for n of 1 or 2); then the final pairs are read and the result
// is issued. The result, the n-th smallest of the 2n values, sits in an output register,
// and loading of the next set proceeds while it waits to be taken; a result still waiting
// when the next search ends stretches that search until it is taken.
module median_of_two_sorted_lists_core
  import mtsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // [31:0] value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [31:0] median
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LEN_W-1:0]  list_length;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] last, idx;
  logic              sel_b, cfg_wr, in_acc, last_b;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  srch_cmd_t         cmd;
  srch_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LIST_LENGTH);
  assign prdata = (paddr[2] == REG_LIST_LENGTH) ? {{(32-LEN_W){1'b0}}, list_length} : '0;

  always_comb begin
    if (list_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (list_length > LEN_W'(MAX_LEN)) begin
      len_eff = LEN_W'(MAX_LEN);
    end else begin
      len_eff = list_length;
    end
  end
  assign last = ADDR_W'(len_eff - 1'b1);

  assign s_tready = !stat.busy;
  assign in_acc   = s_tvalid && s_tready;
  assign last_b   = in_acc && sel_b && (idx == last);

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_W'(1);
      idx         <= '0;
      sel_b       <= 1'b0;
    end else if (cfg_wr) begin
      list_length <= pwdata[LEN_W-1:0];
      idx         <= '0;
      sel_b       <= 1'b0;
    end else if (in_acc) begin
      if (idx == last) begin
        idx   <= '0;
        sel_b <= !sel_b;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  mtsl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (in_acc && !sel_b),
    .waddr (idx),
    .wdata (s_tdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mtsl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (in_acc && sel_b),
    .waddr (idx),
    .wdata (s_tdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign cmd.start    = last_b;
  assign cmd.last     = last;
  assign cmd.out_free = !m_tvalid || m_tready;

  mtsl_search u_search (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      m_tdata <= stat.result;
    end
  end

endmodule
